### rtl/hsvc_pkg.sv
package hsvc_pkg;

  // Direction codes carried by the mode field
  localparam logic MODE_HSV_TO_RGB = 1'b0;
  localparam logic MODE_RGB_TO_HSV = 1'b1;

  // Fixed colour constants
  localparam logic [7:0] REGION_WIDTH = 8'd43;
  localparam logic [7:0] GREEN_BASE   = 8'd85;
  localparam logic [7:0] BLUE_BASE    = 8'd171;
  localparam logic [7:0] FULL_SCALE   = 8'd255;

  // Divider geometry: 16-bit dividend, 8-bit divisor, 8-bit quotient
  localparam int QUO_BITS       = 8;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;

  // Hue sector of the HSV to RGB path
  typedef enum logic [2:0] {
    HUE_SECTOR_0,
    HUE_SECTOR_1,
    HUE_SECTOR_2,
    HUE_SECTOR_3,
    HUE_SECTOR_4,
    HUE_SECTOR_5
  } hue_sector_t;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(logic [7:0] rem, logic bin, logic [7:0] den);
    logic [8:0] trial;
    logic [8:0] diff;
    trial = {rem, bin};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, diff[7:0]};
    end else begin
      div_step = {1'b0, trial[7:0]};
    end
  endfunction

endpackage

### rtl/hsvc_div_pipe.sv
module hsvc_div_pipe (
  input  logic       clk,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic [7:0]  quo
);

  // Per-stage carried values; stage inputs come from the previous stage
  logic [7:0] rem_in  [hsvc_pkg::DIV_STAGES];
  logic [7:0] low_in  [hsvc_pkg::DIV_STAGES];
  logic [7:0] quo_in  [hsvc_pkg::DIV_STAGES];
  logic [7:0] den_in  [hsvc_pkg::DIV_STAGES];
  logic [7:0] rem_q   [hsvc_pkg::DIV_STAGES];
  logic [7:0] low_q   [hsvc_pkg::DIV_STAGES];
  logic [7:0] quo_q   [hsvc_pkg::DIV_STAGES];
  logic [7:0] den_q   [hsvc_pkg::DIV_STAGES];

  genvar g;
  generate
    for (g = 0; g < hsvc_pkg::DIV_STAGES; g++) begin : g_stage
      logic [7:0] rem_next;
      logic [7:0] low_next;
      logic [7:0] quo_next;

      // Feed the first stage from the ports, later ones from the stage before
      if (g == 0) begin : g_first
        assign rem_in[g] = num[15:8];
        assign low_in[g] = num[7:0];
        assign quo_in[g] = '0;
        assign den_in[g] = den;
      end else begin : g_rest
        assign rem_in[g] = rem_q[g-1];
        assign low_in[g] = low_q[g-1];
        assign quo_in[g] = quo_q[g-1];
        assign den_in[g] = den_q[g-1];
      end

      // Resolve a few quotient bits, MSB first
      always_comb begin
        logic [8:0] step;
        rem_next = rem_in[g];
        low_next = low_in[g];
        quo_next = quo_in[g];
        for (int k = 0; k < hsvc_pkg::BITS_PER_STAGE; k++) begin
          step     = hsvc_pkg::div_step(rem_next, low_next[7], den_in[g]);
          rem_next = step[7:0];
          low_next = {low_next[6:0], 1'b0};
          quo_next = {quo_next[6:0], step[8]};
        end
      end

      // Advance the stage every cycle
      always_ff @(posedge clk) begin
        rem_q[g] <= rem_next;
        low_q[g] <= low_next;
        quo_q[g] <= quo_next;
        den_q[g] <= den_in[g];
      end
    end
  endgenerate

  assign quo = quo_q[hsvc_pkg::DIV_STAGES-1];

endmodule

### rtl/hsvc_hsv_pipe.sv
module hsvc_hsv_pipe (
  input  logic       clk,
  input  logic [7:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  // Stage 1: sector, scaled remainder
  hsvc_pkg::hue_sector_t sector_next;
  logic [7:0]            sector_base;
  logic [7:0]            offset;
  logic [7:0]            rem_next;

  hsvc_pkg::hue_sector_t sector1;
  logic [7:0]            rem1;
  logic [7:0]            sat1;
  logic [7:0]            val1;
  logic                  grey1;

  // Pick the sector by threshold, highest first
  always_comb begin
    priority if (hue >= 8'd215) begin
      sector_next = hsvc_pkg::HUE_SECTOR_5;
      sector_base = 8'd215;
    end else if (hue >= 8'd172) begin
      sector_next = hsvc_pkg::HUE_SECTOR_4;
      sector_base = 8'd172;
    end else if (hue >= 8'd129) begin
      sector_next = hsvc_pkg::HUE_SECTOR_3;
      sector_base = 8'd129;
    end else if (hue >= 8'd86) begin
      sector_next = hsvc_pkg::HUE_SECTOR_2;
      sector_base = 8'd86;
    end else if (hue >= hsvc_pkg::REGION_WIDTH) begin
      sector_next = hsvc_pkg::HUE_SECTOR_1;
      sector_base = hsvc_pkg::REGION_WIDTH;
    end else begin
      sector_next = hsvc_pkg::HUE_SECTOR_0;
      sector_base = 8'd0;
    end
    offset   = hue - sector_base;
    rem_next = 8'({offset, 2'b00} + {1'b0, offset, 1'b0});
  end

  always_ff @(posedge clk) begin
    sector1 <= sector_next;
    rem1    <= rem_next;
    sat1    <= sat;
    val1    <= val;
    grey1   <= (sat == 8'd0);
  end

  // Stage 2: saturation products
  hsvc_pkg::hue_sector_t sector2;
  logic [15:0]           prod_q2;
  logic [15:0]           prod_t2;
  logic [15:0]           prod_p2;
  logic [7:0]            val2;
  logic                  grey2;

  always_ff @(posedge clk) begin
    sector2 <= sector1;
    prod_q2 <= 16'(sat1) * 16'(rem1);
    prod_t2 <= 16'(sat1) * 16'(hsvc_pkg::FULL_SCALE - rem1);
    prod_p2 <= 16'(val1) * 16'(hsvc_pkg::FULL_SCALE - sat1);
    val2    <= val1;
    grey2   <= grey1;
  end

  // Stage 3: value products
  hsvc_pkg::hue_sector_t sector3;
  logic [15:0]           prod_q3;
  logic [15:0]           prod_t3;
  logic [7:0]            term_p3;
  logic [7:0]            val3;
  logic                  grey3;

  always_ff @(posedge clk) begin
    sector3 <= sector2;
    prod_q3 <= 16'(val2) * 16'(hsvc_pkg::FULL_SCALE - prod_q2[15:8]);
    prod_t3 <= 16'(val2) * 16'(hsvc_pkg::FULL_SCALE - prod_t2[15:8]);
    term_p3 <= prod_p2[15:8];
    val3    <= val2;
    grey3   <= grey2;
  end

  // Stage 4: order the channels by sector
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] term_q;
  logic [7:0] term_t;

  always_comb begin
    term_q = prod_q3[15:8];
    term_t = prod_t3[15:8];
    if (grey3) begin
      red_next   = val3;
      green_next = val3;
      blue_next  = val3;
    end else begin
      unique case (sector3)
        hsvc_pkg::HUE_SECTOR_0: begin
          red_next = val3;    green_next = term_t;  blue_next = term_p3;
        end
        hsvc_pkg::HUE_SECTOR_1: begin
          red_next = term_q;  green_next = val3;    blue_next = term_p3;
        end
        hsvc_pkg::HUE_SECTOR_2: begin
          red_next = term_p3; green_next = val3;    blue_next = term_t;
        end
        hsvc_pkg::HUE_SECTOR_3: begin
          red_next = term_p3; green_next = term_q;  blue_next = val3;
        end
        hsvc_pkg::HUE_SECTOR_4: begin
          red_next = term_t;  green_next = term_p3; blue_next = val3;
        end
        default: begin
          red_next = val3;    green_next = term_p3; blue_next = term_q;
        end
      endcase
    end
  end

  logic [7:0] red4;
  logic [7:0] green4;
  logic [7:0] blue4;

  always_ff @(posedge clk) begin
    red4   <= red_next;
    green4 <= green_next;
    blue4  <= blue_next;
  end

  // Stage 5: extra register to line up with the divider path
  always_ff @(posedge clk) begin
    red   <= red4;
    green <= green4;
    blue  <= blue4;
  end

endmodule

### rtl/hsv_rgb_color_converter.sv
// HSV <-> RGB converter, 8 bits per channel, direction chosen per item.
// Input: drive mode, chan_one, chan_two, chan_three and pulse start; an item
// is taken at every clock edge where start is high and busy is low. busy is
// always low, so an item can be issued in every cycle.
// Mode 0 takes hue/saturation/value and returns red/green/blue; mode 1 takes
// red/green/blue and returns hue/saturation/value.
// Output: done is high for exactly one cycle per item, with out_one, out_two
// and out_three valid in that cycle. Results leave in issue order.
// Throughput: one item per cycle. The pipeline depth is set by the two
// pipelined restoring dividers (saturation and hue correction), 2 quotient
// bits per stage over 4 stages, behind one stage for max/min and the
// dividend products and ahead of the output register; the HSV to RGB
// multiplier path is padded to match.
// Reset: rst clears every valid bit, so no done pulse follows reset until a
// new item is taken. The receiver cannot stall; results must be taken on done.
module hsv_rgb_color_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] chan_one,
  input  logic [7:0] chan_two,
  input  logic [7:0] chan_three,
  output logic       done,
  output logic [7:0] out_one,
  output logic [7:0] out_two,
  output logic [7:0] out_three
);

  typedef struct packed {
    logic       mode;
    logic [7:0] hi;
    logic [7:0] base;
    logic       neg;
    logic       span_zero;
    logic       hi_zero;
  } side_t;

  localparam int PIPE_DEPTH = hsvc_pkg::DIV_STAGES + 1;

  assign busy = 1'b0;

  // Front stage of the RGB to HSV path
  logic [7:0]  hi_next;
  logic [7:0]  lo_next;
  logic [7:0]  span_next;
  logic [7:0]  base_next;
  logic [8:0]  diff_next;
  logic [7:0]  mag_next;
  logic [15:0] num_sat_next;
  logic [15:0] num_hue_next;

  always_comb begin
    // Ties go to red, then green
    if (chan_one >= chan_two && chan_one >= chan_three) begin
      hi_next   = chan_one;
      base_next = 8'd0;
      diff_next = {1'b0, chan_two} - {1'b0, chan_three};
    end else if (chan_two >= chan_three) begin
      hi_next   = chan_two;
      base_next = hsvc_pkg::GREEN_BASE;
      diff_next = {1'b0, chan_three} - {1'b0, chan_one};
    end else begin
      hi_next   = chan_three;
      base_next = hsvc_pkg::BLUE_BASE;
      diff_next = {1'b0, chan_one} - {1'b0, chan_two};
    end
    if (chan_one <= chan_two && chan_one <= chan_three) begin
      lo_next = chan_one;
    end else if (chan_two <= chan_three) begin
      lo_next = chan_two;
    end else begin
      lo_next = chan_three;
    end
    span_next    = hi_next - lo_next;
    mag_next     = diff_next[8] ? 8'(-diff_next) : diff_next[7:0];
    num_sat_next = {span_next, 8'd0} - 16'(span_next);
    num_hue_next = 16'(mag_next) * 16'(hsvc_pkg::REGION_WIDTH);
  end

  logic [15:0] num_sat;
  logic [15:0] num_hue;
  logic [7:0]  den_sat;
  logic [7:0]  den_hue;
  side_t       side_a;

  always_ff @(posedge clk) begin
    num_sat          <= num_sat_next;
    num_hue          <= num_hue_next;
    den_sat          <= hi_next;
    den_hue          <= span_next;
    side_a.mode      <= mode;
    side_a.hi        <= hi_next;
    side_a.base      <= base_next;
    side_a.neg       <= diff_next[8];
    side_a.span_zero <= (span_next == 8'd0);
    side_a.hi_zero   <= (hi_next == 8'd0);
  end

  // Dividers for saturation and hue correction
  logic [7:0] quo_sat;
  logic [7:0] quo_hue;

  hsvc_div_pipe u_div_sat (
    .clk (clk),
    .num (num_sat),
    .den (den_sat),
    .quo (quo_sat)
  );

  hsvc_div_pipe u_div_hue (
    .clk (clk),
    .num (num_hue),
    .den (den_hue),
    .quo (quo_hue)
  );

  // HSV to RGB path, same depth as front stage plus divider
  logic [7:0] hsv_red;
  logic [7:0] hsv_green;
  logic [7:0] hsv_blue;

  hsvc_hsv_pipe u_hsv (
    .clk   (clk),
    .hue   (chan_one),
    .sat   (chan_two),
    .val   (chan_three),
    .red   (hsv_red),
    .green (hsv_green),
    .blue  (hsv_blue)
  );

  // Carry sideband alongside the divider stages
  side_t side_q [hsvc_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    side_q[0] <= side_a;
    for (int k = 1; k < hsvc_pkg::DIV_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Valid bits travel with the data
  logic [PIPE_DEPTH-1:0] valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      done    <= 1'b0;
    end else begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], start & ~busy};
      done    <= valid_q[PIPE_DEPTH-1];
    end
  end

  // Final stage: apply hue sign and wrap, pick direction
  side_t      side_last;
  logic [7:0] hue_next;
  logic [7:0] sat_next;
  logic [7:0] one_next;
  logic [7:0] two_next;
  logic [7:0] three_next;

  always_comb begin
    side_last = side_q[hsvc_pkg::DIV_STAGES-1];
    hue_next  = side_last.neg ? (side_last.base - quo_hue) : (side_last.base + quo_hue);
    if (side_last.span_zero) begin
      hue_next = 8'd0;
    end
    sat_next = side_last.hi_zero ? 8'd0 : quo_sat;
    if (side_last.mode == hsvc_pkg::MODE_RGB_TO_HSV) begin
      one_next   = hue_next;
      two_next   = sat_next;
      three_next = side_last.hi;
    end else begin
      one_next   = hsv_red;
      two_next   = hsv_green;
      three_next = hsv_blue;
    end
  end

  always_ff @(posedge clk) begin
    out_one   <= one_next;
    out_two   <= two_next;
    out_three <= three_next;
  end

endmodule
